@@ design/lcc_pkg.sv @@
`default_nettype none

package lcc_pkg;

  // internal fixed-point word: signed, 30 fraction bits
  typedef logic signed [63:0] q_t;
  typedef logic        [63:0] mag_t;

  localparam int FRAC   = 30;
  localparam int RATE_W = 31;
  localparam int NDIR   = 9;

  // unit latencies in enabled cycles
  localparam int SUM_LAT = 8;
  localparam int MUL_LAT = 4;
  localparam int DIV_LAT = 65;

  localparam logic [RATE_W-1:0] RATE_RESET = 31'd1073741824;

  localparam q_t Q_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q_t Q_MIN      = 64'sh8000_0000_0000_0000;
  localparam q_t ONE_Q      = 64'sd1073741824;
  localparam q_t W_REST     = 64'sd477218588;
  localparam q_t W_AXIS     = 64'sd119304647;
  localparam q_t W_DIAG     = 64'sd29826162;
  localparam q_t K_THREE    = 64'sd3221225472;
  localparam q_t K_FOURHALF = 64'sd4831838208;
  localparam q_t K_ONEHALF  = 64'sd1610612736;

  // opposite direction for bounce-back
  typedef logic [3:0] dir_t;
  localparam dir_t SWAP [NDIR] = '{4'd0, 4'd3, 4'd4, 4'd1, 4'd2, 4'd7, 4'd8, 4'd5, 4'd6};

  function automatic q_t sadd(input q_t a, input q_t b);
    q_t s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return Q_MAX;
    if (a[63] && b[63] && !s[63]) return Q_MIN;
    return s;
  endfunction

  function automatic q_t ssub(input q_t a, input q_t b);
    q_t s;
    s = a - b;
    if (!a[63] && b[63] && s[63]) return Q_MAX;
    if (a[63] && !b[63] && !s[63]) return Q_MIN;
    return s;
  endfunction

  function automatic mag_t mag(input q_t a);
    return a[63] ? mag_t'(-a) : mag_t'(a);
  endfunction

  function automatic q_t from_mag(input mag_t m, input logic neg);
    if (neg) return m[63] ? Q_MIN : -q_t'(m);
    return m[63] ? Q_MAX : q_t'(m);
  endfunction

endpackage

`default_nettype wire

@@ design/lattice_cell_collide_unit.sv @@
// throughput: one cell per cycle while the output is not stalled, set by the fully
// pipelined divider and multipliers
// the divider resolves one quotient bit per stage and dominates the depth
// a stalled output beat holds the pipeline only when its last stage is occupied
// reset: synchronous, clears valid bits and sets omega to 1.0; no clearing pass
`default_nettype none

module lattice_cell_collide_unit import lcc_pkg::*; #(
  parameter  int POP_BITS = 32,
  localparam int DATA_W   = ((9 * POP_BITS + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // in_rest, in_east, in_north, in_west, in_south, in_northeast, in_northwest,
  // in_southwest, in_southeast
  input  wire logic [DATA_W-1:0] s_axis_tdata,
  // blocked
  input  wire logic [0:0]        s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // out_rest, out_east, out_north, out_west, out_south, out_northeast,
  // out_northwest, out_southwest, out_southeast
  output logic      [DATA_W-1:0] m_axis_tdata,
  input  wire logic              cfg_wen,
  input  wire logic [RATE_W-1:0] cfg_wdata
);

  localparam int BUN_W    = 9 * POP_BITS + 1;
  localparam int P1_DLY   = SUM_LAT + DIV_LAT + 1 + MUL_LAT + 1 + MUL_LAT + 2 + MUL_LAT;
  localparam int P2_DLY   = 1 + MUL_LAT;
  localparam int WR_DLY   = MUL_LAT + 3;
  localparam int PIPE_LEN = P1_DLY + P2_DLY + 2;
  localparam q_t PMAX     = (64'sd1 <<< (POP_BITS - 1)) - 64'sd1;
  localparam q_t PMIN     = -PMAX - 64'sd1;

  logic [RATE_W-1:0] omega;
  logic              en, out_load;
  logic [PIPE_LEN-1:0] vld;

  logic [BUN_W-1:0] bun0, bun_h, bun_j;
  q_t p0 [NDIR];
  q_t ph [NDIR];
  q_t pj [NDIR];

  q_t rho_m, mx_m, my_m, rho_d, ux_d, uy_d;
  q_t ux_c, uy_c, rho_c;
  q_t cu [NDIR];
  q_t uxx, uyy, wr0, wr1, wr2, wr0_d, wr1_d, wr2_d;
  q_t t3 [NDIR];
  q_t cc [NDIR];
  q_t usq;
  q_t ta [NDIR];
  q_t cc_e [NDIR];
  q_t h [NDIR];
  q_t ta_d [NDIR];
  q_t s15, s_f;
  q_t t1 [NDIR];
  q_t tt [NDIR];
  q_t feq [NDIR];
  q_t dd [NDIR];
  q_t mm [NDIR];
  q_t omega_q;
  logic [DATA_W-1:0] res_next, res;

  // output register parts the two sides
  assign out_load      = !m_axis_tvalid || m_axis_tready;
  assign en            = out_load || !vld[PIPE_LEN-1];
  assign s_axis_tready = en;
  assign omega_q       = q_t'({33'd0, omega});

  // relaxation register
  always_ff @(posedge clk) begin
    if (rst) begin
      omega <= RATE_RESET;
    end else if (cfg_wen) begin
      omega <= cfg_wdata;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LEN-2:0], s_axis_tvalid};
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (en) begin
      bun0 <= {s_axis_tuser[0], s_axis_tdata[9*POP_BITS-1:0]};
    end
  end

  // sign-extended views of the population bundle
  for (genvar i = 0; i < NDIR; i++) begin : g_view
    logic signed [POP_BITS-1:0] f0, fh, fj;
    assign f0    = bun0[i*POP_BITS +: POP_BITS];
    assign fh    = bun_h[i*POP_BITS +: POP_BITS];
    assign fj    = bun_j[i*POP_BITS +: POP_BITS];
    assign p0[i] = 64'(f0);
    assign ph[i] = 64'(fh);
    assign pj[i] = 64'(fj);
  end

  lcc_dly #(.W(BUN_W), .D(P1_DLY)) u_dly_p1 (.clk, .en, .din(bun0), .dout(bun_h));
  lcc_dly #(.W(BUN_W), .D(P2_DLY)) u_dly_p2 (.clk, .en, .din(bun_h), .dout(bun_j));

  // density and momentum
  lcc_moment u_moment (.clk, .en, .p(p0), .rho(rho_m), .mx(mx_m), .my(my_m));

  // velocity
  lcc_div u_div_x (.clk, .en, .num(mx_m), .den(rho_m), .quo(ux_d));
  lcc_div u_div_y (.clk, .en, .num(my_m), .den(rho_m), .quo(uy_d));
  lcc_dly #(.W(64), .D(DIV_LAT)) u_dly_rho (.clk, .en, .din(rho_m), .dout(rho_d));

  // projections of the velocity on each direction
  always_ff @(posedge clk) begin
    if (en) begin
      ux_c  <= ux_d;
      uy_c  <= uy_d;
      rho_c <= rho_d;
      cu[0] <= '0;
      cu[1] <= ux_d;
      cu[2] <= uy_d;
      cu[3] <= ssub('0, ux_d);
      cu[4] <= ssub('0, uy_d);
      cu[5] <= sadd(ux_d, uy_d);
      cu[6] <= ssub(uy_d, ux_d);
      cu[7] <= ssub(ssub('0, ux_d), uy_d);
      cu[8] <= ssub(ux_d, uy_d);
    end
  end

  // first product rank
  lcc_mul u_mul_xx (.clk, .en, .a(ux_c), .b(ux_c), .y(uxx));
  lcc_mul u_mul_yy (.clk, .en, .a(uy_c), .b(uy_c), .y(uyy));
  lcc_mul u_mul_w0 (.clk, .en, .a(W_REST), .b(rho_c), .y(wr0));
  lcc_mul u_mul_w1 (.clk, .en, .a(W_AXIS), .b(rho_c), .y(wr1));
  lcc_mul u_mul_w2 (.clk, .en, .a(W_DIAG), .b(rho_c), .y(wr2));
  lcc_dly #(.W(64), .D(WR_DLY)) u_dly_w0 (.clk, .en, .din(wr0), .dout(wr0_d));
  lcc_dly #(.W(64), .D(WR_DLY)) u_dly_w1 (.clk, .en, .din(wr1), .dout(wr1_d));
  lcc_dly #(.W(64), .D(WR_DLY)) u_dly_w2 (.clk, .en, .din(wr2), .dout(wr2_d));

  // speed squared
  always_ff @(posedge clk) begin
    if (en) begin
      usq <= sadd(uxx, uyy);
    end
  end

  lcc_mul u_mul_s15 (.clk, .en, .a(K_ONEHALF), .b(usq), .y(s15));

  always_ff @(posedge clk) begin
    if (en) begin
      s_f <= s15;
    end
  end

  // per-direction equilibrium and relaxation lanes
  for (genvar i = 0; i < NDIR; i++) begin : g_lane
    q_t wsel;

    lcc_mul u_mul_t3 (.clk, .en, .a(K_THREE), .b(cu[i]), .y(t3[i]));
    lcc_mul u_mul_cc (.clk, .en, .a(cu[i]), .b(cu[i]), .y(cc[i]));

    always_ff @(posedge clk) begin
      if (en) begin
        ta[i]   <= sadd(ONE_Q, t3[i]);
        cc_e[i] <= cc[i];
      end
    end

    lcc_mul u_mul_h (.clk, .en, .a(K_FOURHALF), .b(cc_e[i]), .y(h[i]));
    lcc_dly #(.W(64), .D(MUL_LAT)) u_dly_ta (.clk, .en, .din(ta[i]), .dout(ta_d[i]));

    // polynomial sum in written order
    always_ff @(posedge clk) begin
      if (en) begin
        t1[i] <= sadd(ta_d[i], h[i]);
        tt[i] <= ssub(t1[i], s_f);
      end
    end

    if (i == 0) begin : g_w0
      assign wsel = wr0_d;
    end else if (i < 5) begin : g_w1
      assign wsel = wr1_d;
    end else begin : g_w2
      assign wsel = wr2_d;
    end

    lcc_mul u_mul_feq (.clk, .en, .a(wsel), .b(tt[i]), .y(feq[i]));

    always_ff @(posedge clk) begin
      if (en) begin
        dd[i] <= ssub(feq[i], ph[i]);
      end
    end

    lcc_mul u_mul_om (.clk, .en, .a(omega_q), .b(dd[i]), .y(mm[i]));
  end

  // final sum, clamp, bounce-back select
  always_comb begin
    q_t v;
    res_next = '0;
    for (int i = 0; i < NDIR; i++) begin
      v = sadd(pj[i], mm[i]);
      if (v > PMAX) v = PMAX;
      if (v < PMIN) v = PMIN;
      if (bun_j[BUN_W-1]) begin
        res_next[i*POP_BITS +: POP_BITS] = bun_j[int'(SWAP[i])*POP_BITS +: POP_BITS];
      end else begin
        res_next[i*POP_BITS +: POP_BITS] = v[POP_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= vld[PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= res;
    end
  end

`ifndef ASSERT_OFF
  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready && vld[PIPE_LEN-1]) |-> !s_axis_tready)
    else $error("pipeline advanced into a full output register");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[0])
    else $error("accepted beat lost at pipeline entry");

  a_free_when_empty: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid) |-> s_axis_tready)
    else $error("pipeline stalled with an empty output register");

  a_last_moves: assert property (@(posedge clk) disable iff (rst)
    (vld[PIPE_LEN-1] && out_load) |=> m_axis_tvalid)
    else $error("finished beat did not reach the output register");
`endif

endmodule

`default_nettype wire

@@ design/lcc_dly.sv @@
`default_nettype none

module lcc_dly #(
  parameter int W = 64,
  parameter int D = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);

  logic [W-1:0] taps [D];

  // shift line, advances with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int k = 1; k < D; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  assign dout = taps[D-1];

endmodule

`default_nettype wire

@@ design/lcc_mul.sv @@
`default_nettype none

module lcc_mul import lcc_pkg::*; (
  input  wire logic clk,
  input  wire logic en,
  input  wire q_t   a,
  input  wire q_t   b,
  output q_t        y
);

  mag_t         ma, mb;
  logic         ng0, ng1, ng2;
  logic [63:0]  p00, p01, p10, p11;
  logic [127:0] prod;
  logic [127:0] rnd;

  // rounding to nearest on the magnitude, ties away from zero
  assign rnd = prod + (128'd1 << (FRAC - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes and sign
      ma  <= mag(a);
      mb  <= mag(b);
      ng0 <= a[63] ^ b[63];
      // four 32x32 partial products
      p00 <= 64'(ma[31:0])  * 64'(mb[31:0]);
      p01 <= 64'(ma[31:0])  * 64'(mb[63:32]);
      p10 <= 64'(ma[63:32]) * 64'(mb[31:0]);
      p11 <= 64'(ma[63:32]) * 64'(mb[63:32]);
      ng1 <= ng0;
      // full product
      prod <= {64'd0, p00} + ({64'd0, p01} << 32) + ({64'd0, p10} << 32) + {p11, 64'd0};
      ng2  <= ng1;
      // scale back and saturate
      if (|rnd[127:94]) y <= ng2 ? Q_MIN : Q_MAX;
      else              y <= from_mag(rnd[93:30], ng2);
    end
  end

endmodule

`default_nettype wire

@@ design/lcc_div.sv @@
`default_nettype none

module lcc_div import lcc_pkg::*; (
  input  wire logic clk,
  input  wire logic en,
  input  wire q_t   num,
  input  wire q_t   den,
  output q_t        quo
);

  localparam int STEPS = 63;

  mag_t        un, ud_in;
  logic [63:0] rem_s [STEPS+1];
  logic [62:0] nb_s  [STEPS+1];
  logic [62:0] q_s   [STEPS+1];
  mag_t        ud_s  [STEPS+1];
  logic        neg_s [STEPS+1];
  logic        ovf_s [STEPS+1];
  logic        zero_s[STEPS+1];
  logic [64:0] rem2  [1:STEPS];
  logic        ge    [1:STEPS];

  assign un    = mag(num);
  assign ud_in = mag(den);

  // one restoring step per stage
  always_comb begin
    for (int k = 1; k <= STEPS; k++) begin
      rem2[k] = {rem_s[k-1], nb_s[k-1][62]};
      ge[k]   = rem2[k] >= {1'b0, ud_s[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // set-up: integer-part overflow check and seed remainder
      rem_s[0]  <= 64'(un[63:33]);
      nb_s[0]   <= {un[32:0], 30'd0};
      q_s[0]    <= '0;
      ud_s[0]   <= ud_in;
      neg_s[0]  <= num[63] ^ den[63];
      ovf_s[0]  <= {33'd0, un} >= {ud_in, 33'd0};
      zero_s[0] <= ud_in == '0;
      for (int k = 1; k <= STEPS; k++) begin
        rem_s[k]  <= ge[k] ? 64'(rem2[k] - {1'b0, ud_s[k-1]}) : rem2[k][63:0];
        nb_s[k]   <= {nb_s[k-1][61:0], 1'b0};
        q_s[k]    <= {q_s[k-1][61:0], ge[k]};
        ud_s[k]   <= ud_s[k-1];
        neg_s[k]  <= neg_s[k-1];
        ovf_s[k]  <= ovf_s[k-1];
        zero_s[k] <= zero_s[k-1];
      end
      // sign, saturation and zero divisor
      if (zero_s[STEPS])     quo <= '0;
      else if (ovf_s[STEPS]) quo <= neg_s[STEPS] ? Q_MIN : Q_MAX;
      else                   quo <= from_mag({1'b0, q_s[STEPS]}, neg_s[STEPS]);
    end
  end

endmodule

`default_nettype wire

@@ design/lcc_moment.sv @@
`default_nettype none

module lcc_moment import lcc_pkg::*; (
  input  wire logic clk,
  input  wire logic en,
  input  wire q_t   p [NDIR],
  output q_t        rho,
  output q_t        mx,
  output q_t        my
);

  q_t ps  [SUM_LAT-1][NDIR];
  q_t acc [SUM_LAT];
  q_t ea, eb, na, nb;
  q_t mx_s [2:SUM_LAT];
  q_t my_s [2:SUM_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      // first stage: density and the first momentum pairs
      ps[0]  <= p;
      acc[0] <= sadd(p[0], p[1]);
      ea     <= sadd(p[1], p[5]);
      eb     <= sadd(p[3], p[6]);
      na     <= sadd(p[2], p[5]);
      nb     <= sadd(p[4], p[7]);
      // density keeps its left-to-right order, one add a stage
      for (int k = 1; k < SUM_LAT; k++) begin
        if (k < SUM_LAT - 1) begin
          ps[k] <= ps[k-1];
        end
        acc[k] <= sadd(acc[k-1], ps[k-1][k+1]);
      end
      // third terms, then difference of the two sides
      mx_s[2] <= ssub(sadd(ea, ps[0][8]), sadd(eb, ps[0][7]));
      my_s[2] <= ssub(sadd(na, ps[0][6]), sadd(nb, ps[0][8]));
      // momentum waits for the density
      for (int k = 3; k <= SUM_LAT; k++) begin
        mx_s[k] <= mx_s[k-1];
        my_s[k] <= my_s[k-1];
      end
    end
  end

  assign rho = acc[SUM_LAT-1];
  assign mx  = mx_s[SUM_LAT];
  assign my  = my_s[SUM_LAT];

endmodule

`default_nettype wire
